[rtl/efd_pkg.sv]
// ----------------------------------------------------------------------------
// efd_pkg
// shared constants for the frame difference event generator
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam int DefMaxWidth  = 64;
  localparam int DefMaxHeight = 64;

  localparam int DimW  = 7;
  localparam int CodeW = 13;
  localparam int CfgIdxW = 1;

  localparam logic [DimW-1:0] DimReset = 7'd64;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 1'b1;

  // pixel change codes
  localparam logic signed [1:0] ChangeNone = 2'sd0;
  localparam logic signed [1:0] ChangeRise = 2'sd1;
  localparam logic signed [1:0] ChangeFall = -2'sd1;

endpackage

[rtl/efd_store.sv]
// ----------------------------------------------------------------------------
// efd_store
// one bit per pixel store of the previous frame, cleared after reset
// ----------------------------------------------------------------------------
module efd_store import efd_pkg::*; #(
  parameter int Depth = DefMaxWidth * DefMaxHeight,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic             rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic             wr_data_i,
  output logic             busy_o
);

  logic             mem [Depth];
  logic             mem_rd_q;
  logic             byp_q;
  logic             byp_data_q;
  logic             clr_q, clr_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;

  // clearing pass, one entry per cycle
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= 1'b0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mem_rd_q   <= mem[rd_addr_i];
      byp_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      byp_data_q <= wr_data_i;
    end
  end

  // write-first on a same-address read
  assign rd_data_o = byp_q ? byp_data_q : mem_rd_q;
  assign busy_o    = clr_q;

endmodule

[rtl/efd_raster.sv]
// ----------------------------------------------------------------------------
// efd_raster
// frame size registers and raster position counters
// ----------------------------------------------------------------------------
module efd_raster import efd_pkg::*; #(
  parameter int MaxWidth  = DefMaxWidth,
  parameter int MaxHeight = DefMaxHeight,
  localparam int Depth = MaxWidth * MaxHeight,
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  input  logic               step_i,
  output logic [IdxW-1:0]    idx_o,
  output logic               last_o
);

  localparam int ColW  = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int RowW  = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int WCmpW = (DimW > $clog2(MaxWidth + 1)) ? DimW : $clog2(MaxWidth + 1);
  localparam int HCmpW = (DimW > $clog2(MaxHeight + 1)) ? DimW : $clog2(MaxHeight + 1);

  logic [DimW-1:0]  width_q, height_q;
  logic [ColW-1:0]  col_q, col_d, col_last;
  logic [RowW-1:0]  row_q, row_d, row_last;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [WCmpW-1:0] w_ext;
  logic [HCmpW-1:0] h_ext;
  logic             row_end;

  // clamped last column and row
  always_comb begin
    w_ext = WCmpW'(width_q);
    h_ext = HCmpW'(height_q);
    priority if (w_ext == '0) begin
      col_last = '0;
    end else if (w_ext > WCmpW'(MaxWidth)) begin
      col_last = ColW'(MaxWidth - 1);
    end else begin
      col_last = ColW'(w_ext - 1'b1);
    end
    priority if (h_ext == '0) begin
      row_last = '0;
    end else if (h_ext > HCmpW'(MaxHeight)) begin
      row_last = RowW'(MaxHeight - 1);
    end else begin
      row_last = RowW'(h_ext - 1'b1);
    end
  end

  assign row_end = col_q >= col_last;
  assign last_o  = row_end && (row_q >= row_last);
  assign idx_o   = idx_q;

  always_comb begin
    col_d = col_q + 1'b1;
    row_d = row_q;
    idx_d = (idx_q == IdxW'(Depth - 1)) ? '0 : idx_q + 1'b1;
    priority if (last_o) begin
      col_d = '0;
      row_d = '0;
      idx_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      idx_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimReset;
      height_q <= DimReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFrameWidth:  width_q  <= cfg_data_i;
        CfgFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

[rtl/event_camera_frame_diff.sv]
// ----------------------------------------------------------------------------
// event_camera_frame_diff
// frame difference event generator: compares each pixel with the last frame
// ----------------------------------------------------------------------------
// pipeline: a taken pixel passes the compare stage, then the result register
// throughput: one pixel per cycle while not stalled, the store reads one entry and
//   writes another; pixel_ready_o drops while the store is clearing, or while both
//   stages hold a word and result_ready_i is low
// reset: all MaxWidth*MaxHeight store entries (4096 by default) are cleared,
//   pixel_ready_o low meanwhile; cfg_ready_o is always high
// ----------------------------------------------------------------------------
module event_camera_frame_diff import efd_pkg::*; #(
  parameter int MaxWidth  = DefMaxWidth,
  parameter int MaxHeight = DefMaxHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DimW-1:0]     cfg_data_i,
  input  logic                pixel_valid_i,
  output logic                pixel_ready_o,
  input  logic                pixel_bit_i,
  output logic                result_valid_o,
  input  logic                result_ready_i,
  output logic signed [1:0]   pixel_change_o,
  output logic                spike_valid_o,
  output logic [CodeW-1:0]    event_code_o,
  output logic                frame_end_o
);

  localparam int Depth = MaxWidth * MaxHeight;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic              accept, s1_adv, busy;
  logic [IdxW-1:0]   idx;
  logic              last;
  logic              old_bit;
  logic              s1_valid_q;
  logic              s1_bit_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic              s1_last_q;
  logic              out_valid_q;
  logic signed [1:0] change_q, change_d;
  logic              spike_q, spike_d;
  logic [CodeW-1:0]  code_q, code_d;
  logic              end_q;

  assign accept        = pixel_valid_i && pixel_ready_o;
  assign s1_adv        = s1_valid_q && (!out_valid_q || result_ready_i);
  assign pixel_ready_o = !busy && (!s1_valid_q || s1_adv);
  assign cfg_ready_o   = 1'b1;

  efd_raster #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (accept),
    .idx_o       (idx),
    .last_o      (last)
  );

  efd_store #(
    .Depth (Depth)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (idx),
    .rd_data_o (old_bit),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (s1_bit_q),
    .busy_o    (busy)
  );

  // compare stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bit_q  <= pixel_bit_i;
      s1_idx_q  <= idx;
      s1_last_q <= last;
    end
  end

  always_comb begin
    change_d = ChangeNone;
    spike_d  = 1'b0;
    code_d   = '0;
    if (s1_bit_q != old_bit) begin
      change_d = s1_bit_q ? ChangeRise : ChangeFall;
      spike_d  = 1'b1;
      code_d   = CodeW'({s1_idx_q, old_bit});
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      change_q <= change_d;
      spike_q  <= spike_d;
      code_q   <= code_d;
      end_q    <= s1_last_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign pixel_change_o = change_q;
  assign spike_valid_o  = spike_q;
  assign event_code_o   = code_q;
  assign frame_end_o    = end_q;

endmodule

[tb/tb_event_camera_frame_diff.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_camera_frame_diff
// drives binary pixel words into the frame difference block under random
// gaps and stalls, predicts every result word from a model of the stored
// frame and the raster counters, and checks each field as it leaves
// ----------------------------------------------------------------------------
module tb_event_camera_frame_diff;
  import efd_pkg::*;

  localparam int StoreDepth  = DefMaxWidth * DefMaxHeight;
  localparam int RandomItems = 1750;
  localparam int HoldCycles  = 400;

  typedef struct {
    logic signed [1:0] change;
    logic              spike;
    logic [CodeW-1:0]  code;
    logic              fend;
  } diff_word_t;

  class frame_diff_scoreboard;
    bit               prior_bits [StoreDepth];
    int               col;
    int               row;
    int               pix_idx;
    logic [DimW-1:0]  width_reg;
    logic [DimW-1:0]  height_reg;
    diff_word_t       expected_words [$];
    int               errors;

    function new();
      foreach (prior_bits[i]) prior_bits[i] = 1'b0;
      col        = 0;
      row        = 0;
      pix_idx    = 0;
      width_reg  = DimReset;
      height_reg = DimReset;
      errors     = 0;
    endfunction

    function void set_dim(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] data);
      if (idx == CfgFrameWidth) begin
        width_reg = data;
      end else begin
        height_reg = data;
      end
    endfunction

    // zero acts as one, anything past the maximum dimension acts as that maximum
    function int span(logic [DimW-1:0] v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_pixel(logic b);
      int         w;
      int         h;
      int         addr;
      bit         old;
      bit         row_end;
      bit         last;
      diff_word_t word;
      w           = span(width_reg, DefMaxWidth);
      h           = span(height_reg, DefMaxHeight);
      addr        = pix_idx % StoreDepth;
      old         = prior_bits[addr];
      word.change = ChangeNone;
      word.spike  = 1'b0;
      word.code   = '0;
      if (b && !old) begin
        word.change = ChangeRise;
        word.spike  = 1'b1;
        word.code   = CodeW'(pix_idx * 2);
      end else if (!b && old) begin
        word.change = ChangeFall;
        word.spike  = 1'b1;
        word.code   = CodeW'(pix_idx * 2 + 1);
      end
      prior_bits[addr] = b;
      row_end = (col >= w - 1);
      last    = row_end && (row >= h - 1);
      if (last) begin
        col     = 0;
        row     = 0;
        pix_idx = 0;
      end else if (row_end) begin
        col     = 0;
        row     = row + 1;
        pix_idx = (pix_idx + 1) % StoreDepth;
      end else begin
        col     = col + 1;
        pix_idx = (pix_idx + 1) % StoreDepth;
      end
      word.fend = last;
      expected_words.insert(expected_words.size(), word);
    endfunction

    function void compare_field(string name, logic signed [15:0] exp_v,
                                logic signed [15:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(logic signed [1:0] change, logic spike,
                             logic [CodeW-1:0] code, logic fend);
      diff_word_t word;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with no pixel pending, expected none actual %0d/%0d/%0d/%0d",
                 $time, change, spike, code, fend);
        errors++;
        return;
      end
      word = expected_words.pop_front();
      compare_field("pixel_change", word.change, change);
      compare_field("spike_valid", word.spike, spike);
      compare_field("event_code", word.code, code);
      compare_field("frame_end", word.fend, fend);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxW-1:0]      cfg_index = CfgFrameWidth;
  logic [DimW-1:0]         cfg_data = '0;
  logic                    pixel_valid = 1'b0;
  logic                    pixel_ready;
  logic                    pixel_bit = 1'b0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic signed [1:0]       pixel_change;
  logic                    spike_valid;
  logic [CodeW-1:0]        event_code;
  logic                    frame_end;

  bit                      pix_gaps_on = 1'b1;
  bit                      rsp_gaps_on = 1'b1;
  bit                      hold_req = 1'b0;
  int                      hold_left = 0;

  frame_diff_scoreboard    sb = new();

  event_camera_frame_diff i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pixel_valid_i  (pixel_valid),
    .pixel_ready_o  (pixel_ready),
    .pixel_bit_i    (pixel_bit),
    .result_valid_o (result_valid),
    .result_ready_i (result_ready),
    .pixel_change_o (pixel_change),
    .spike_valid_o  (spike_valid),
    .event_code_o   (event_code),
    .frame_end_o    (frame_end)
  );

  always #2 clk = ~clk;

  // result side: check accepted words, random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst_n && result_valid && result_ready) begin
      sb.check_word(pixel_change, spike_valid, event_code, frame_end);
    end
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= !(rsp_gaps_on && $urandom_range(99) < 12);
    end
  end

  task automatic send_pixel(input logic b);
    while (pix_gaps_on && $urandom_range(99) < 12) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_bit   <= b;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    sb.note_pixel(b);
  endtask

  task automatic send_pattern(input logic [7:0] pattern, input int n);
    for (int i = 0; i < n; i++) send_pixel(pattern[i]);
  endtask

  task automatic drain_results();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dim(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_dim(idx, data);
  endtask

  // registers only change once the block has gone quiet
  task automatic set_frame(input bit set_w, input logic [DimW-1:0] w,
                           input bit set_h, input logic [DimW-1:0] h);
    drain_results();
    if (set_w) write_dim(CfgFrameWidth, w);
    if (set_h) write_dim(CfgFrameHeight, h);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DimW-1:0] pick_dim();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return DimW'($urandom_range(65, 127));
    if (r == 2) return DimW'(64);
    return DimW'($urandom_range(1, 10));
  endfunction

  initial begin
    int              sent;
    int              n;
    int              bias;
    int              phase;
    int              sel;
    bit              held;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // rises, falls and unchanged pixels over two small frames
    set_frame(1'b1, 7'd3, 1'b1, 7'd2);
    send_pattern(8'b00001101, 6);
    send_pattern(8'b00110100, 6);
    // zero sizes act as one pixel per frame
    set_frame(1'b1, 7'd0, 1'b1, 7'd0);
    send_pattern(8'b00000110, 4);
    // oversized registers act as the full store
    set_frame(1'b1, 7'd127, 1'b1, 7'd127);
    send_pattern(8'b00000011, 2);
    // shrink mid-row, then mid-frame
    set_frame(1'b1, 7'd2, 1'b0, 7'd0);
    send_pattern(8'b00000101, 3);
    set_frame(1'b0, 7'd0, 1'b1, 7'd1);
    send_pattern(8'b00000100, 3);

    sent  = 0;
    phase = 0;
    held  = 1'b0;
    while (sent < RandomItems) begin
      w   = pick_dim();
      h   = pick_dim();
      sel = $urandom_range(2);
      set_frame(sel != 1, w, sel != 0, h);
      n   = $urandom_range(20, 120);
      sel = $urandom_range(2);
      bias = (sel == 0) ? 50 : (sel == 1) ? 10 : 90;
      if (phase == 4) begin
        pix_gaps_on = 1'b0;
        rsp_gaps_on = 1'b0;
        n = 300;
      end
      if (!held && sent > 600) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      repeat (n) begin
        send_pixel($urandom_range(99) < bias);
        sent++;
      end
      pix_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      phase++;
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
